// ===== rtl/cmap_pkg.sv =====
// Shared types, codes and saturating helpers for the calibration matrix apply unit.
// Depends on nothing; every other file imports it.
package cmap_pkg;

   localparam int SB = 16;                  // bits per real or imaginary part
   localparam int FB = 12;                  // fraction bits
   localparam int PROD_W = 2 * SB;
   localparam int ACC_W = 2 * SB + 8;       // eight products plus headroom
   localparam int DIV_NUM_BITS = SB + 2 * FB;

   localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
   localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};
   // 1.0, saturated to the sample width
   localparam logic signed [SB-1:0] CONE = (FB >= SB - 1) ? SMAX : SB'(1 << FB);

   localparam logic [1:0] FN_LOAD   = 2'd0;
   localparam logic [1:0] FN_APPLY  = 2'd1;
   localparam logic [1:0] FN_INVERT = 2'd2;
   localparam logic [1:0] FN_FILL   = 2'd3;

   localparam logic [2:0] MD_GENERAL  = 3'd0;
   localparam logic [2:0] MD_DIAG     = 3'd1;
   localparam logic [2:0] MD_TWO      = 3'd2;
   localparam logic [2:0] MD_SCALAR   = 3'd3;
   localparam logic [2:0] MD_ADD_DIAG = 3'd4;
   localparam logic [2:0] MD_ADD_TWO  = 3'd5;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_SHORT   = 2'd1;
   localparam logic [1:0] ST_ILLEGAL = 2'd2;

   localparam logic [3:0] CSR_MODE   = 4'd0;
   localparam logic [3:0] CSR_SCALAR = 4'd1;

   typedef struct packed {
      logic               [1:0]  func;
      logic               [3:0]  elem_index;
      logic signed        [15:0] elem_re;
      logic signed        [15:0] elem_im;
      logic                      elem_ok;
      logic               [2:0]  vis_count;
      logic               [31:0] vis_0;
      logic               [31:0] vis_1;
      logic               [31:0] vis_2;
      logic               [31:0] vis_3;
      logic                      has_flags;
      logic               [3:0]  in_flags;
   } req_type;

   typedef struct packed {
      logic [31:0] out_0;
      logic [31:0] out_1;
      logic [31:0] out_2;
      logic [31:0] out_3;
      logic [3:0]  out_flags;
      logic        row_flag;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic signed [SB-1:0] re;
      logic signed [SB-1:0] im;
   } cval_type;

   typedef struct packed {
      logic valid;    // products of this step go to the accumulator
      logic first;    // first step of a vector: clear accumulator, capture add operands
      logic add;      // additive modes: result is a saturated sum
   } lane_ctl_type;

   function automatic logic signed [SB-1:0] sat_add(input logic signed [SB-1:0] a,
                                                    input logic signed [SB-1:0] b);
      logic signed [SB:0] s;
      s = (SB+1)'(a) + (SB+1)'(b);
      if (s[SB] != s[SB-1]) return s[SB] ? SMIN : SMAX;
      return s[SB-1:0];
   endfunction

   function automatic logic signed [SB-1:0] neg_sat(input logic signed [SB-1:0] a);
      if (a == SMIN) return SMAX;
      return -a;
   endfunction

   function automatic cval_type unpack_vis(input logic [2*SB-1:0] w);
      cval_type c;
      c.re = w[SB-1:0];
      c.im = w[2*SB-1:SB];
      return c;
   endfunction

   function automatic logic [2*SB-1:0] pack_vis(input cval_type c);
      return {c.im, c.re};
   endfunction

endpackage

// ===== rtl/cmap_lane.sv =====
// One correction lane: registered complex products, exact accumulation,
// round-half-up and saturation; also the saturated sum of the additive modes.
// Depends on cmap_pkg.
module cmap_lane
   import cmap_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  lane_ctl_type ctl,
   input  cval_type     m,
   input  cval_type     v,
   output cval_type     result
);

   localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FB - 1);

   logic signed [PROD_W-1:0] rr_ff, ii_ff, ri_ff, ir_ff;
   logic signed [PROD_W-1:0] rr_in, ii_in, ri_in, ir_in;
   logic                     pv_ff, pf_ff, add_ff;
   cval_type                 sum_ff;
   logic signed [ACC_W-1:0]  acc_re_ff, acc_im_ff;

   assign rr_in = m.re * v.re;
   assign ii_in = m.im * v.im;
   assign ri_in = m.re * v.im;
   assign ir_in = m.im * v.re;

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      rr_ff <= rr_in;
      ii_ff <= ii_in;
      ri_ff <= ri_in;
      ir_ff <= ir_in;
      pf_ff <= ctl.first;
      if (ctl.valid && ctl.first) begin
         add_ff    <= ctl.add;
         sum_ff.re <= sat_add(m.re, v.re);
         sum_ff.im <= sat_add(m.im, v.im);
      end
      if (pv_ff) begin
         acc_re_ff <= (pf_ff ? '0 : acc_re_ff) + ACC_W'(rr_ff) - ACC_W'(ii_ff);
         acc_im_ff <= (pf_ff ? '0 : acc_im_ff) + ACC_W'(ri_ff) + ACC_W'(ir_ff);
      end
   end

   function automatic logic signed [SB-1:0] round_sat(input logic signed [ACC_W-1:0] a);
      logic signed [ACC_W-1:0] t;
      t = (a + HALF) >>> FB;
      if (!((&t[ACC_W-1:SB-1]) || !(|t[ACC_W-1:SB-1]))) return t[ACC_W-1] ? SMIN : SMAX;
      return t[SB-1:0];
   endfunction

   always_comb begin
      if (add_ff) begin
         result = sum_ff;
      end else begin
         result.re = round_sat(acc_re_ff);
         result.im = round_sat(acc_im_ff);
      end
   end

endmodule

// ===== rtl/cmap_div.sv =====
// Radix-2 restoring divider for reciprocal parts: |x| * 2^(2F) / den,
// rounded to nearest (ties away from zero), signed and saturated.
// Depends on cmap_pkg.
module cmap_div
   import cmap_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [SB-1:0]           mag,
   input  logic                    neg,
   input  logic [2*SB-1:0]         den,
   output logic                    done,
   output logic signed [SB-1:0]    quot
);

   localparam int CW = $clog2(DIV_NUM_BITS);

   logic                    busy_ff, fin_ff, neg_ff;
   logic [CW-1:0]           cnt_ff;
   logic [DIV_NUM_BITS-1:0] num_ff;
   logic [2*SB-1:0]         rem_ff, den_ff;
   logic [2*SB:0]           trial;
   logic                    fits;
   logic                    up;
   logic [DIV_NUM_BITS:0]   qr;

   assign trial = {rem_ff, num_ff[DIV_NUM_BITS-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
      end else begin
         fin_ff <= busy_ff && (cnt_ff == CW'(DIV_NUM_BITS - 1));
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == CW'(DIV_NUM_BITS - 1))) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= {mag, (2*FB)'(0)};
         rem_ff <= '0;
         den_ff <= den;
         neg_ff <= neg;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= fits ? (2*SB)'(trial - {1'b0, den_ff}) : trial[2*SB-1:0];
         num_ff <= {num_ff[DIV_NUM_BITS-2:0], fits};
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   // round up when the remainder is at least half the divisor
   assign up   = {rem_ff, 1'b0} >= {1'b0, den_ff};
   assign qr   = (DIV_NUM_BITS+1)'(num_ff) + (DIV_NUM_BITS+1)'(up);
   assign done = fin_ff;

   always_comb begin
      if (neg_ff) begin
         if (qr > (DIV_NUM_BITS+1)'(2 ** (SB - 1))) quot = SMIN;
         else quot = ~qr[SB-1:0] + 1'b1;
      end else begin
         if (qr > (DIV_NUM_BITS+1)'(2 ** (SB - 1) - 1)) quot = SMAX;
         else quot = qr[SB-1:0];
      end
   end

endmodule

// ===== rtl/calibration_matrix_apply_unit.sv =====
// Calibration matrix apply unit. Apply: four product steps, a drain step, a merge step and an
// output step; no new request is taken until its result is written. Loads, fills, additive
// inverts, illegal and short requests answer the cycle after the request, one per cycle unless stalled.
// Reciprocal invert: each usable nonzero entry is divided by the radix-2 divider, part by part.
// Synchronous active-high reset clears the matrix to zero and unusable and the mode registers.
module calibration_matrix_apply_unit
   import cmap_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [31:0] csr_data
);

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_APPLY  = 8'b0000_0010,
      S_CHK    = 8'b0000_0100,
      S_SQ_RE  = 8'b0000_1000,
      S_SQ_IM  = 8'b0001_0000,
      S_DIV_RE = 8'b0010_0000,
      S_DIV_IM = 8'b0100_0000,
      S_RSP    = 8'b1000_0000
   } state_type;

   state_type       state_ff, state_in;
   logic [2:0]      mode_ff;
   logic            scal_ff;
   cval_type        ent_ff [16];
   cval_type        ent_in [16];
   logic [15:0]     ok_ff, ok_in;
   req_type         req_ff;
   rsp_type         rsp_ff, pend_ff, pend_in, rsp_now, rsp_apply;
   logic            rsp_valid_ff;
   logic [2:0]      cnt_ff;
   logic [1:0]      e_ff;
   logic [PROD_W-1:0] sq_ff;
   logic signed [SB-1:0] rre_ff;

   logic            slot_free, accept, rsp_wr;
   logic            additive, illegal, short_vec, immediate;
   logic [2:0]      n_mode, n_vis, n_cur;
   logic            last_e, chk_ok;
   cval_type        cur;

   lane_ctl_type    lane_ctl [4];
   cval_type        lane_m   [4];
   cval_type        lane_v   [4];
   cval_type        lane_res [4];
   logic [31:0]     vis_w    [4];
   logic [3:0]      present;
   logic [3:0]      lidx     [4];

   logic            div_start, div_neg, div_done;
   logic [SB-1:0]   div_mag;
   logic signed [SB-1:0] div_x, div_q;
   logic [PROD_W-1:0] div_den;

   assign csr_ready = 1'b1;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !slot_free;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign additive = (mode_ff == MD_ADD_DIAG) || (mode_ff == MD_ADD_TWO);
   always_comb begin
      unique case (mode_ff)
         MD_DIAG, MD_ADD_DIAG: n_mode = 3'd4;
         MD_TWO, MD_ADD_TWO:   n_mode = 3'd2;
         default:              n_mode = 3'd1;
      endcase
   end

   always_comb begin
      case (req_data.vis_count)
         3'd1:    n_vis = 3'd1;
         3'd2:    n_vis = 3'd2;
         default: n_vis = 3'd4;
      endcase
      case (req_ff.vis_count)
         3'd1:    n_cur = 3'd1;
         3'd2:    n_cur = 3'd2;
         default: n_cur = 3'd4;
      endcase
   end

   assign illegal   = (req_data.func != FN_LOAD) &&
                      ((mode_ff > MD_ADD_TWO) ||
                       ((req_data.func != FN_APPLY) && (mode_ff == MD_GENERAL)));
   assign short_vec = !illegal && (req_data.func == FN_APPLY) &&
                      (mode_ff == MD_GENERAL) && (n_vis != 3'd4);
   assign immediate = illegal || short_vec || (req_data.func == FN_LOAD) ||
                      (req_data.func == FN_FILL) ||
                      ((req_data.func == FN_INVERT) && additive);

   always_comb begin
      rsp_now = '0;
      if (illegal) rsp_now.status = ST_ILLEGAL;
      else if (short_vec) rsp_now.status = ST_SHORT;
      else rsp_now.status = ST_OK;
   end

   // entry selection of the non-general modes
   assign vis_w[0] = req_ff.vis_0;
   assign vis_w[1] = req_ff.vis_1;
   assign vis_w[2] = req_ff.vis_2;
   assign vis_w[3] = req_ff.vis_3;

   always_comb begin
      present = 4'b0000;
      for (int k = 0; k < 4; k++) lidx[k] = 4'd0;
      case (mode_ff)
         MD_DIAG, MD_ADD_DIAG: begin
            if (n_cur == 3'd4) begin
               present = 4'b1111;
               lidx[1] = 4'd1;
               lidx[2] = 4'd2;
               lidx[3] = 4'd3;
            end else if (n_cur == 3'd2) begin
               present = 4'b0011;
               lidx[1] = 4'd3;
            end else begin
               present = 4'b0001;
            end
         end
         MD_TWO, MD_ADD_TWO: begin
            if (n_cur == 3'd4) begin
               present = 4'b1001;
               lidx[3] = 4'd1;
            end else if (n_cur == 3'd2) begin
               present = 4'b0011;
               lidx[1] = 4'd1;
            end else begin
               present = 4'b0001;
            end
         end
         default: begin
            if (n_cur == 3'd4) present = 4'b1111;
            else if (n_cur == 3'd2) present = 4'b0011;
            else present = 4'b0001;
         end
      endcase
   end

   for (genvar k = 0; k < 4; k++) begin : g_lane
      always_comb begin
         lane_ctl[k] = '0;
         if (mode_ff == MD_GENERAL) begin
            lane_ctl[k].valid = (state_ff == S_APPLY) && (cnt_ff < 3'd4);
            lane_ctl[k].first = (cnt_ff == 3'd0);
            lane_m[k] = ent_ff[{2'(k), cnt_ff[1:0]}];
            lane_v[k] = unpack_vis(vis_w[cnt_ff[1:0]]);
         end else begin
            lane_ctl[k].valid = (state_ff == S_APPLY) && (cnt_ff == 3'd0);
            lane_ctl[k].first = 1'b1;
            lane_ctl[k].add   = additive;
            lane_m[k] = ent_ff[lidx[k]];
            lane_v[k] = unpack_vis(vis_w[k]);
         end
      end

      cmap_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctl    (lane_ctl[k]),
         .m      (lane_m[k]),
         .v      (lane_v[k]),
         .result (lane_res[k])
      );
   end

   // merge: corrected vector, flags and row flag
   always_comb begin
      logic [3:0] fbits;
      logic [31:0] o [4];
      rsp_apply = '0;
      fbits = 4'b0000;
      for (int k = 0; k < 4; k++) begin
         if (mode_ff == MD_GENERAL || present[k]) o[k] = pack_vis(lane_res[k]);
         else o[k] = '0;
         if (present[k] && !ok_ff[lidx[k]]) fbits[k] = 1'b1;
      end
      rsp_apply.out_0 = o[0];
      rsp_apply.out_1 = o[1];
      rsp_apply.out_2 = o[2];
      rsp_apply.out_3 = o[3];
      rsp_apply.status = ST_OK;
      if (mode_ff == MD_GENERAL) begin
         rsp_apply.out_flags = req_ff.has_flags ? req_ff.in_flags : 4'b0000;
      end else begin
         rsp_apply.out_flags = req_ff.has_flags ? (req_ff.in_flags | fbits) : 4'b0000;
         if (mode_ff == MD_SCALAR || scal_ff) rsp_apply.row_flag = !ok_ff[0];
         else if (mode_ff == MD_DIAG || mode_ff == MD_ADD_DIAG)
            rsp_apply.row_flag = !(&ok_ff[3:0]);
         else rsp_apply.row_flag = !(&ok_ff[1:0]);
      end
   end

   // reciprocal sequencing over the entries in use
   assign cur    = ent_ff[{2'b00, e_ff}];
   assign chk_ok = ok_ff[{2'b00, e_ff}] && ((cur.re != '0) || (cur.im != '0));
   assign last_e = ({1'b0, e_ff} == n_mode - 3'd1);

   assign div_start = (state_ff == S_SQ_IM) || ((state_ff == S_DIV_RE) && div_done);
   assign div_x     = (state_ff == S_SQ_IM) ? cur.re : cur.im;
   assign div_neg   = div_x[SB-1] ^ (state_ff != S_SQ_IM);
   assign div_mag   = div_x[SB-1] ? (~div_x + 1'b1) : div_x;
   assign div_den   = sq_ff + PROD_W'(cur.im * cur.im);

   cmap_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .mag   (div_mag),
      .neg   (div_neg),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_q)
   );

   always_comb begin
      ent_in = ent_ff;
      ok_in  = ok_ff;
      if (accept && !illegal) begin
         case (req_data.func)
            FN_LOAD: begin
               ent_in[req_data.elem_index].re = req_data.elem_re;
               ent_in[req_data.elem_index].im = req_data.elem_im;
               ok_in[req_data.elem_index]     = req_data.elem_ok;
            end
            FN_FILL: begin
               for (int e = 0; e < 4; e++) begin
                  if (3'(e) < n_mode && !ok_ff[e]) begin
                     ent_in[e].re = additive ? '0 : CONE;
                     ent_in[e].im = '0;
                  end
               end
            end
            FN_INVERT: begin
               if (additive) begin
                  for (int e = 0; e < 4; e++) begin
                     if (3'(e) < n_mode) begin
                        if (ok_ff[e]) begin
                           ent_in[e].re = neg_sat(ent_ff[e].re);
                           ent_in[e].im = neg_sat(ent_ff[e].im);
                        end else begin
                           ent_in[e] = '0;
                        end
                     end
                  end
               end
            end
            default: ;
         endcase
      end
      if (state_ff == S_CHK && !chk_ok) begin
         ent_in[{2'b00, e_ff}] = '0;
         ok_in[{2'b00, e_ff}]  = 1'b0;
      end
      if (state_ff == S_DIV_IM && div_done) begin
         ent_in[{2'b00, e_ff}].re = rre_ff;
         ent_in[{2'b00, e_ff}].im = div_q;
      end
   end

   always_comb begin
      state_in = state_ff;
      pend_in  = pend_ff;
      rsp_wr   = accept && immediate;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && !immediate) begin
               state_in = (req_data.func == FN_APPLY) ? S_APPLY : S_CHK;
            end
         end
         S_APPLY: begin
            if (cnt_ff == 3'd5) begin
               pend_in  = rsp_apply;
               state_in = S_RSP;
            end
         end
         S_CHK: begin
            if (chk_ok) state_in = S_SQ_RE;
            else if (last_e) begin
               pend_in  = '0;
               state_in = S_RSP;
            end
         end
         S_SQ_RE:  state_in = S_SQ_IM;
         S_SQ_IM:  state_in = S_DIV_RE;
         S_DIV_RE: if (div_done) state_in = S_DIV_IM;
         S_DIV_IM: begin
            if (div_done) begin
               if (last_e) begin
                  pend_in  = '0;
                  state_in = S_RSP;
               end else begin
                  state_in = S_CHK;
               end
            end
         end
         S_RSP: begin
            if (slot_free) begin
               rsp_wr   = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MD_GENERAL;
         scal_ff      <= 1'b0;
         ok_ff        <= '0;
         for (int e = 0; e < 16; e++) ent_ff[e] <= '0;
         cnt_ff       <= '0;
         e_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_wr || (rsp_valid_ff && rsp_stall);
         ok_ff        <= ok_in;
         ent_ff       <= ent_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_MODE:   mode_ff <= csr_data[2:0];
               CSR_SCALAR: scal_ff <= csr_data[0];
               default: ;
            endcase
         end
         if (accept) cnt_ff <= '0;
         else if (state_ff == S_APPLY) cnt_ff <= cnt_ff + 1'b1;
         if (accept) e_ff <= '0;
         else if ((state_ff == S_CHK && !chk_ok && !last_e) ||
                  (state_ff == S_DIV_IM && div_done && !last_e)) e_ff <= e_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) req_ff <= req_data;
      pend_ff <= pend_in;
      if (rsp_wr) rsp_ff <= accept ? rsp_now : pend_ff;
      if (state_ff == S_SQ_RE) sq_ff <= PROD_W'(cur.re * cur.re);
      if (state_ff == S_DIV_RE && div_done) rre_ff <= div_q;
   end

`ifndef SYNTH
   // a held result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_ff))
      else $error("pending result overwritten");
   // a multi-cycle request blocks the next one
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      accept && !immediate |=> req_stall)
      else $error("request accepted while busy");
   // divider results arrive only while a reciprocal is in progress
   a_div_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV_RE) || (state_ff == S_DIV_IM))
      else $error("stray divider result");
`endif

endmodule

// ===== verif/tb_calibration_matrix_apply_unit.sv =====
// Self-checking testbench for the calibration matrix apply unit: random and directed requests,
// an internal predictor of matrix state and correction algebra, scoreboard on every response.
// Depends on rtl/cmap_pkg.sv and rtl/calibration_matrix_apply_unit.sv.
module tb_calibration_matrix_apply_unit
   import cmap_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [3:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   calibration_matrix_apply_unit i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [31:0] cal_entry [16];
   logic        cal_usable [16];
   logic [2:0]  cur_mode;
   logic        cur_scalar;

   req_type pending_reqs [$];
   rsp_type expected_rsps [$];
   int      errors = 0;
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;
   int      quiet_cycles = 0;

   function automatic longint sx16(input logic [15:0] v);
      return longint'($signed(v));
   endfunction

   function automatic longint sat16(input longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic logic [31:0] pk(input longint re, input longint im);
      logic [15:0] r, i;
      r = re[15:0];
      i = im[15:0];
      return {i, r};
   endfunction

   // Exact sum of products, then round half up at the fraction point.
   function automatic longint round_sum(input longint s);
      return sat16((s + (64'sd1 <<< (FB - 1))) >>> FB);
   endfunction

   function automatic longint recip_part(input longint x, input longint den, input bit flip);
      bit neg;
      longint mag, num, q, r;
      neg = (x < 0) != flip;
      mag = (x < 0) ? -x : x;
      num = mag <<< (2 * FB);
      q = num / den;
      r = num % den;
      if (r >= den - r) q++;
      return sat16(neg ? -q : q);
   endfunction

   function automatic logic [31:0] rq_vis(input req_type rq, input int k);
      case (k)
         0: return rq.vis_0;
         1: return rq.vis_1;
         2: return rq.vis_2;
         default: return rq.vis_3;
      endcase
   endfunction

   function automatic void set_out(inout rsp_type o, input int k, input logic [31:0] v);
      case (k)
         0: o.out_0 = v;
         1: o.out_1 = v;
         2: o.out_2 = v;
         default: o.out_3 = v;
      endcase
   endfunction

   function automatic rsp_type predict_correction(input req_type rq);
      rsp_type o;
      int n, ent[4];
      bit add;
      logic [3:0] fb;
      logic [31:0] vw;
      longint mr, mi, vr, vi, sr, si;
      o = '0;
      add = (cur_mode == MD_ADD_DIAG) || (cur_mode == MD_ADD_TWO);
      if (rq.func == FN_LOAD) begin
         cal_entry[rq.elem_index] = {rq.elem_im, rq.elem_re};
         cal_usable[rq.elem_index] = rq.elem_ok;
         return o;
      end
      if (cur_mode > MD_ADD_TWO || (rq.func != FN_APPLY && cur_mode == MD_GENERAL)) begin
         o.status = ST_ILLEGAL;
         return o;
      end
      if (rq.func != FN_APPLY) begin
         n = (cur_mode == MD_DIAG || cur_mode == MD_ADD_DIAG) ? 4 :
             (cur_mode == MD_TWO || cur_mode == MD_ADD_TWO) ? 2 : 1;
         for (int e = 0; e < n; e++) begin
            mr = sx16(cal_entry[e][15:0]);
            mi = sx16(cal_entry[e][31:16]);
            if (rq.func == FN_FILL) begin
               if (!cal_usable[e]) cal_entry[e] = add ? 32'd0 : pk(1 << FB, 0);
            end else if (add ? cal_usable[e] : (cal_usable[e] && (mr != 0 || mi != 0))) begin
               if (add) cal_entry[e] = pk(sat16(-mr), sat16(-mi));
               else cal_entry[e] = pk(recip_part(mr, mr*mr + mi*mi, 1'b0),
                                      recip_part(mi, mr*mr + mi*mi, 1'b1));
            end else begin
               cal_entry[e] = '0;
               cal_usable[e] = 1'b0;
            end
         end
         return o;
      end
      n = (rq.vis_count == 1) ? 1 : (rq.vis_count == 2) ? 2 : 4;
      if (cur_mode == MD_GENERAL) begin
         if (n != 4) begin
            o.status = ST_SHORT;
            return o;
         end
         for (int k = 0; k < 4; k++) begin
            sr = 0;
            si = 0;
            for (int e = 0; e < 4; e++) begin
               mr = sx16(cal_entry[4*k+e][15:0]);
               mi = sx16(cal_entry[4*k+e][31:16]);
               vw = rq_vis(rq, e);
               vr = sx16(vw[15:0]);
               vi = sx16(vw[31:16]);
               sr += mr*vr - mi*vi;
               si += mr*vi + mi*vr;
            end
            set_out(o, k, pk(round_sum(sr), round_sum(si)));
         end
         o.out_flags = rq.has_flags ? rq.in_flags : 4'd0;
         return o;
      end
      ent = '{-1, -1, -1, -1};
      if (cur_mode == MD_DIAG || cur_mode == MD_ADD_DIAG) begin
         if (n == 4) ent = '{0, 1, 2, 3};
         else if (n == 2) ent = '{0, 3, -1, -1};
         else ent[0] = 0;
      end else if (cur_mode == MD_TWO || cur_mode == MD_ADD_TWO) begin
         if (n == 4) ent = '{0, -1, -1, 1};
         else if (n == 2) ent = '{0, 1, -1, -1};
         else ent[0] = 0;
      end else begin
         for (int k = 0; k < n; k++) ent[k] = 0;
      end
      fb = '0;
      for (int k = 0; k < 4; k++) begin
         if (ent[k] >= 0) begin
            mr = sx16(cal_entry[ent[k]][15:0]);
            mi = sx16(cal_entry[ent[k]][31:16]);
            vw = rq_vis(rq, k);
            vr = sx16(vw[15:0]);
            vi = sx16(vw[31:16]);
            if (add) set_out(o, k, pk(sat16(mr + vr), sat16(mi + vi)));
            else set_out(o, k, pk(round_sum(mr*vr - mi*vi), round_sum(mr*vi + mi*vr)));
            if (!cal_usable[ent[k]]) fb[k] = 1'b1;
         end
      end
      o.out_flags = rq.has_flags ? (rq.in_flags | fb) : 4'd0;
      if (cur_mode == MD_SCALAR || cur_scalar) o.row_flag = !cal_usable[0];
      else if (cur_mode == MD_DIAG || cur_mode == MD_ADD_DIAG)
         o.row_flag = !(cal_usable[0] && cal_usable[1] && cal_usable[2] && cal_usable[3]);
      else o.row_flag = !(cal_usable[0] && cal_usable[1]);
      return o;
   endfunction

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) expected_rsps.push_back(predict_correction(req_data));
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= pending_reqs.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset) begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response %h", $realtime, rsp_data);
               errors++;
            end else begin
               exp_rsp = expected_rsps.pop_front();
               if (rsp_data !== exp_rsp) begin
                  $display("%0t: mismatch expected %h actual %h", $realtime, exp_rsp, rsp_data);
                  errors++;
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   function automatic req_type rand_req(input logic [1:0] f);
      req_type r;
      r = '0;
      r.func = f;
      r.elem_index = 4'($urandom_range(15));
      r.elem_re = 16'($urandom);
      r.elem_im = 16'($urandom);
      if ($urandom_range(3) == 0) r.elem_re = 16'(1 << FB);
      if ($urandom_range(3) == 0) r.elem_im = '0;
      r.elem_ok = ($urandom_range(3) != 0);
      r.vis_count = ($urandom_range(4) == 0) ? 3'($urandom_range(7)) : 3'(1 << $urandom_range(2));
      r.vis_0 = $urandom;
      r.vis_1 = $urandom;
      r.vis_2 = $urandom;
      r.vis_3 = $urandom;
      r.has_flags = 1'($urandom_range(1));
      r.in_flags = 4'($urandom_range(15));
      return r;
   endfunction

   task automatic drain_all();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_csr(input logic [3:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_MODE) cur_mode = val[2:0];
      else if (idx == CSR_SCALAR) cur_scalar = val[0];
      @(posedge clock);
   endtask

   initial begin
      req_type r;
      logic [2:0] mode_seq [8];
      int idle_tab [4][2];
      foreach (cal_entry[i]) begin
         cal_entry[i] = '0;
         cal_usable[i] = 1'b0;
      end
      cur_mode = MD_GENERAL;
      cur_scalar = 1'b0;
      mode_seq = '{MD_DIAG, MD_GENERAL, MD_TWO, MD_SCALAR, MD_ADD_DIAG, MD_ADD_TWO, 3'd7, 3'd6};
      idle_tab = '{'{0, 0}, '{78, 0}, '{0, 78}, '{10, 10}};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, every function, short general vector, illegal ops
      for (int i = 0; i < 16; i++) begin
         r = rand_req(FN_LOAD);
         r.elem_index = 4'(i);
         r.elem_re = (i % 3 == 0) ? 16'h8000 : (i % 3 == 1) ? 16'h7fff : 16'h0000;
         r.elem_im = (i % 2) ? 16'h8000 : 16'h7fff;
         r.elem_ok = (i != 5);
         pending_reqs.push_back(r);
      end
      r = rand_req(FN_APPLY);
      r.vis_count = 3'd4;
      r.vis_0 = 32'h8000_8000;
      r.vis_1 = 32'h7fff_7fff;
      r.vis_2 = 32'hffff_ffff;
      r.vis_3 = 32'h0000_0000;
      pending_reqs.push_back(r);
      r.vis_count = 3'd2;
      pending_reqs.push_back(r);
      pending_reqs.push_back(rand_req(FN_INVERT));
      pending_reqs.push_back(rand_req(FN_FILL));
      drain_all();

      for (int ph = 0; ph < 16; ph++) begin
         write_csr(CSR_MODE, {29'd0, mode_seq[ph % 8]});
         write_csr(CSR_SCALAR, {31'd0, 1'($urandom_range(1))});
         send_idle_pct = idle_tab[ph % 4][0];
         recv_stall_pct = idle_tab[ph % 4][1];
         // per phase: load the entries, maybe fix them up, then mostly applies with occasional loads
         for (int i = 0; i < 80; i++) begin
            if (i < 6) r = rand_req(FN_LOAD);
            else if ($urandom_range(19) == 0) r = rand_req(2'($urandom_range(2, 3)));
            else r = rand_req(($urandom_range(9) == 0) ? FN_LOAD : FN_APPLY);
            pending_reqs.push_back(r);
            if (ph == 3 && i == 40) begin
               // sender holds off until every outstanding response is back
               while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
                  @(posedge clock);
            end
         end
         drain_all();
      end

      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/cmap_pkg.sv
rtl/cmap_lane.sv
rtl/cmap_div.sv
rtl/calibration_matrix_apply_unit.sv
verif/tb_calibration_matrix_apply_unit.sv
